### src/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Depends on nothing; every other file imports it.
`default_nettype none

package ple_pkg;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // decoded command handed from the controller to the cell row
   typedef struct packed {
      logic                ins;
      logic                rem;
      logic                rd;
      logic [STATUS_W-1:0] status;
   } ple_op_type;

endpackage

`default_nettype wire

### src/ple_if.sv
// Request and response channel interfaces for the positional list engine.
// Depends on ple_pkg for the field widths.
`default_nettype none

interface ple_req_if
   import ple_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output read_value, output status, output count, input ready);
   modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

### src/ple_cell.sv
// One slot of the list: holds, loads, or takes its left or right neighbor.
// Depends on ple_pkg for the decoded command struct.
`default_nettype none

module ple_cell
   import ple_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int SLOT_W     = 4,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire ple_op_type            op,
   input  wire logic [SLOT_W-1:0]     op_pos,
   input  wire logic [DATA_WIDTH-1:0] load_data,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output logic      [DATA_WIDTH-1:0] data,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  hit;
   logic                  above;

   assign hit   = (MY_IDX == op_pos);
   assign above = (MY_IDX > op_pos);

   always_comb begin
      data_in = data_ff;
      if (op.ins) begin
         if (above) begin
            data_in = left_data;
         end else if (hit) begin
            data_in = load_data;
         end
      end else if (op.rem) begin
         // close the gap: everything from the removed slot up moves down
         if (above || hit) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (op.rd && hit) ? data_ff : '0;

endmodule

`default_nettype wire

### src/ple_ctrl.sv
// Length register and command decode for the positional list engine.
// Depends on ple_pkg for command, status codes and the op struct.
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int LEN_W    = $clog2(CAPACITY + 1),
   parameter int SLOT_W   = $clog2(CAPACITY)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [CMD_W-1:0]   cmd,
   input  wire logic [POS_W-1:0]   position,
   output ple_op_type              op,
   output logic      [SLOT_W-1:0]  op_pos,
   output logic      [LEN_W-1:0]   len,
   output logic      [LEN_W-1:0]   new_len
);

   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    len_in;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    len_ext;
   logic [CMP_W-1:0]    sel_pos;
   logic                full;
   logic                empty;
   logic                do_ins;
   logic                do_rem;
   logic                do_rd;
   logic [STATUS_W-1:0] status;

   assign pos_ext = CMP_W'(position);
   assign len_ext = CMP_W'(len_ff);
   assign full    = (len_ff == LEN_W'(CAPACITY));
   assign empty   = (len_ff == '0);

   always_comb begin
      do_ins  = 1'b0;
      do_rem  = 1'b0;
      do_rd   = 1'b0;
      status  = ST_OK;
      sel_pos = '0;
      unique case (cmd)
         CMD_APPEND: begin
            sel_pos = len_ext;
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         CMD_PUSH: begin
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         CMD_INSERT: begin
            // an empty list takes the item at the front whatever the position
            if (empty) begin
               do_ins = 1'b1;
            end else if (pos_ext > len_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               do_ins  = 1'b1;
               sel_pos = pos_ext;
            end
         end
         CMD_POP: begin
            if (empty) status = ST_RANGE;
            else       do_rem = 1'b1;
         end
         CMD_REMOVE: begin
            sel_pos = pos_ext;
            if (pos_ext >= len_ext) status = ST_RANGE;
            else                    do_rem = 1'b1;
         end
         CMD_READ: begin
            sel_pos = pos_ext;
            if (pos_ext >= len_ext) status = ST_RANGE;
            else                    do_rd  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      new_len = len_ff;
      if (do_ins)      new_len = len_ff + LEN_W'(1);
      else if (do_rem) new_len = len_ff - LEN_W'(1);
   end

   assign len_in = fire ? new_len : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // a valid position is always below CAPACITY, so the narrowing is safe
   assign op_pos    = SLOT_W'(sel_pos);
   assign op.ins    = do_ins & fire;
   assign op.rem    = do_rem & fire;
   assign op.rd     = do_rd;
   assign op.status = status;
   assign len       = len_ff;

endmodule

`default_nettype wire

### src/positional_list_engine.sv
// Positional list engine: ordered list of up to CAPACITY values in a row of shift cells.
// The response beat is registered and valid in the cycle after the request beat is accepted.
// One command per cycle unless a full response register holds it; every cell shifts, loads or holds in the same cycle.
// A new request is taken while the response register is empty or being drained.
// Reset clears the length and the response valid; slot contents are not cleared.
// Depends on ple_pkg, ple_if, ple_ctrl and ple_cell.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ple_req_if.sink    req_bus,
   ple_rsp_if.source  rsp_bus
);

   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int SLOT_W = $clog2(CAPACITY);

   ple_op_type            op;
   logic [SLOT_W-1:0]     op_pos;
   logic [LEN_W-1:0]      len;
   logic [LEN_W-1:0]      new_len;
   logic                  fire;
   logic [DATA_WIDTH-1:0] load_data;
   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_any;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VALUE_W-1:0]  read_value_ff;
   logic [VALUE_W-1:0]  read_value_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;
   assign load_data     = DATA_WIDTH'(req_bus.value);

   ple_ctrl #(
      .CAPACITY (CAPACITY),
      .LEN_W    (LEN_W),
      .SLOT_W   (SLOT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .cmd      (req_bus.cmd),
      .position (req_bus.position),
      .op       (op),
      .op_pos   (op_pos),
      .len      (len),
      .new_len  (new_len)
   );

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      // the row ends feed back their own data; the top cell just holds when its right input is selected
      localparam int LEFT  = (k == 0) ? 0 : k - 1;
      localparam int RIGHT = (k == CAPACITY - 1) ? k : k + 1;

      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .SLOT_W     (SLOT_W),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .op_pos     (op_pos),
         .load_data  (load_data),
         .left_data  (cell_data[LEFT]),
         .right_data (cell_data[RIGHT]),
         .data       (cell_data[k]),
         .rd_data    (cell_rd[k])
      );
   end

   // at most one cell drives a nonzero read word
   always_comb begin
      rd_any = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_any = rd_any | cell_rd[k];
      end
   end

   assign read_value_in = fire ? VALUE_W'(rd_any)    : read_value_ff;
   assign status_in     = fire ? op.status           : status_ff;
   assign count_in      = fire ? COUNT_W'(new_len)   : count_ff;
   assign rsp_valid_in  = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_value_ff <= read_value_in;
      status_ff     <= status_in;
      count_ff      <= count_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = read_value_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.count      = count_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted request did not produce a response beat");

   a_len_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(len))
      else $error("list length changed without a request beat");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len <= LEN_W'(CAPACITY))
      else $error("list length exceeds capacity");

   a_no_shift_on_error: assert property (@(posedge clock) disable iff (reset)
      (op.status != ST_OK) |-> !(op.ins || op.rem))
      else $error("cell row shifted on a failed command");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for positional_list_engine: a directed command table, then random fill,
// drain and mixed bursts, each reply checked against the table's fixed reply or an in-bench list predictor.
// Depends on ple_pkg, ple_if and the engine RTL.

module tb;
   import ple_pkg::*;

   localparam int LIST_CAP     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 20;

   // codes the engine decodes to nothing
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      logic               fixed;
      reply_type          reply;
   } stim_row_type;

   logic clock;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [VALUE_W-1:0] list_slots [LIST_CAP];
   int                 list_len = 0;
   reply_type          awaited_replies [$];
   stim_row_type       directed_rows [$];
   int                 fail_count  = 0;
   int                 cycle_count = 0;
   int                 stall_left  = 0;
   bit                 no_idle     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_list_engine test failed");
         $finish;
      end
   end

   // shift the tail up one slot and load v at p
   task automatic list_place(input int p, input logic [VALUE_W-1:0] v);
      for (int k = list_len; k > p; k--)
         list_slots[k] = list_slots[k - 1];
      list_slots[p] = v;
      list_len++;
   endtask

   // shift the tail down over p
   task automatic list_drop(input int p);
      for (int k = p; k + 1 < list_len; k++)
         list_slots[k] = list_slots[k + 1];
      list_len--;
   endtask

   task automatic apply_list_op(input stim_row_type s, output reply_type r);
      bit full;
      r    = '0;
      full = (list_len >= LIST_CAP);
      case (s.cmd)
         CMD_APPEND: begin
            if (full) r.status = ST_FULL;
            else list_place(list_len, s.value);
         end
         CMD_PUSH: begin
            if (full) r.status = ST_FULL;
            else list_place(0, s.value);
         end
         CMD_INSERT: begin
            // empty list takes the value whatever the position
            if (list_len == 0) list_place(0, s.value);
            else if (s.position > list_len) r.status = ST_RANGE;
            else if (full) r.status = ST_FULL;
            else list_place(s.position, s.value);
         end
         CMD_POP: begin
            if (list_len == 0) r.status = ST_RANGE;
            else list_drop(0);
         end
         CMD_REMOVE: begin
            if (s.position >= list_len) r.status = ST_RANGE;
            else list_drop(s.position);
         end
         CMD_READ: begin
            if (s.position >= list_len) r.status = ST_RANGE;
            else r.read_value = list_slots[s.position];
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_len);
   endtask

   // mostly no gap, some short, a few long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                          input logic [VALUE_W-1:0] v, input logic fixed,
                          input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
      stim_row_type row;
      row.cmd              = c;
      row.position         = p;
      row.value            = v;
      row.fixed            = fixed;
      row.reply.read_value = '0;
      row.reply.status     = st;
      row.reply.count      = cnt;
      directed_rows.push_back(row);
   endtask

   function automatic stim_row_type make_item(input burst_kind_type kind);
      stim_row_type s;
      int           r;
      s = '0;
      r = $urandom_range(0, 99);
      case (kind)
         BURST_FILL:
            s.cmd = (r < 35) ? CMD_APPEND : (r < 60) ? CMD_PUSH :
                    (r < 90) ? CMD_INSERT : CMD_READ;
         BURST_DRAIN:
            s.cmd = (r < 30) ? CMD_POP : (r < 70) ? CMD_REMOVE :
                    (r < 92) ? CMD_READ : CMD_APPEND;
         default:
            s.cmd = CMD_W'($urandom_range(CMD_APPEND, CMD_SPARE_HI));
      endcase
      r = $urandom_range(0, 99);
      if (r < 80) s.position = POS_W'($urandom_range(0, list_len));
      else if (r < 92) s.position = POS_W'(list_len + 1);
      else s.position = POS_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10) s.value = '0;
      else if (r < 20) s.value = '1;
      else s.value = $urandom;
      return s;
   endfunction

   task automatic send_beat(input stim_row_type s);
      int        gap;
      reply_type predicted;
      gap = idle_cycles();
      if (gap > 0) begin
         // idle bus carries junk
         req_bus.valid    <= 1'b0;
         req_bus.cmd      <= CMD_W'($urandom);
         req_bus.position <= POS_W'($urandom);
         req_bus.value    <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= s.cmd;
      req_bus.position <= s.position;
      req_bus.value    <= s.value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_list_op(s, predicted);
      awaited_replies.push_back(s.fixed ? s.reply : predicted);
   endtask

   always @(posedge clock) begin : reply_check
      reply_type got;
      reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.read_value = rsp_bus.read_value;
         got.status     = rsp_bus.status;
         got.count      = rsp_bus.count;
         if (awaited_replies.size() == 0) begin
            $display("%0t: reply beat with none awaited: read_value %h status %0d count %0d",
                     $time, got.read_value, got.status, got.count);
            fail_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (got.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h got %h",
                        $time, want.read_value, got.read_value);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               fail_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = idle_cycles();
      end
   end

   initial begin : stimulus
      stim_row_type   item;
      burst_kind_type kind;
      int             random_items;
      int             burst_len;
      int             r;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_APPEND;
      req_bus.position <= '0;
      req_bus.value    <= '0;

      // empty list after reset
      add_row(CMD_READ,     5'd0,  32'h0,         1'b1, ST_RANGE, 5'd0);
      add_row(CMD_POP,      5'd0,  32'h0,         1'b1, ST_RANGE, 5'd0);
      add_row(CMD_REMOVE,   5'd0,  32'h0,         1'b1, ST_RANGE, 5'd0);
      add_row(CMD_INSERT,   5'd31, 32'hFFFF_FFFF, 1'b1, ST_OK,    5'd1);
      add_row(CMD_INSERT,   5'd3,  32'h0,         1'b1, ST_RANGE, 5'd1);
      add_row(CMD_INSERT,   5'd0,  32'h0,         1'b0, ST_OK,    5'd0);
      add_row(CMD_PUSH,     5'd0,  32'hA5A5_5A5A, 1'b0, ST_OK,    5'd0);
      add_row(CMD_APPEND,   5'd0,  32'h0000_0001, 1'b0, ST_OK,    5'd0);
      add_row(CMD_INSERT,   5'd4,  32'h8000_0000, 1'b0, ST_OK,    5'd0);
      add_row(CMD_REMOVE,   5'd5,  32'h0,         1'b1, ST_RANGE, 5'd5);
      add_row(CMD_READ,     5'd31, 32'h0,         1'b1, ST_RANGE, 5'd5);
      add_row(CMD_SPARE_LO, 5'd0,  32'h0,         1'b1, ST_OK,    5'd5);
      add_row(CMD_SPARE_HI, 5'd31, 32'hFFFF_FFFF, 1'b1, ST_OK,    5'd5);
      // top up to a full list
      for (int k = 0; k < 11; k++)
         add_row((k % 2) ? CMD_PUSH : CMD_APPEND, POS_W'(k), {8{4'(k)}} ^ 32'h5A5A_0F0F,
                 1'b0, ST_OK, 5'd0);
      add_row(CMD_APPEND,   5'd0,  32'h1234_5678, 1'b1, ST_FULL,  COUNT_W'(LIST_CAP));
      add_row(CMD_PUSH,     5'd0,  32'h1234_5678, 1'b1, ST_FULL,  COUNT_W'(LIST_CAP));
      add_row(CMD_INSERT,   5'd16, 32'h1234_5678, 1'b1, ST_FULL,  COUNT_W'(LIST_CAP));
      add_row(CMD_INSERT,   5'd17, 32'h1234_5678, 1'b1, ST_RANGE, COUNT_W'(LIST_CAP));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i]);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 40) kind = BURST_FILL;
         else if (r < 75) kind = BURST_DRAIN;
         else kind = BURST_MIX;
         no_idle   = ($urandom_range(0, 3) == 0);
         burst_len = $urandom_range(8, 40);
         repeat (burst_len) begin
            item = make_item(kind);
            send_beat(item);
            random_items++;
         end
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("positional_list_engine test passed");
      else
         $display("positional_list_engine test failed");
      $finish;
   end

endmodule

### positional_list_engine.f
src/ple_pkg.sv
src/ple_if.sv
src/ple_cell.sv
src/ple_ctrl.sv
src/positional_list_engine.sv
sim/tb.sv
